[rtl/spi_register_transaction_framer_assert.svh]
// assertion macros shared by the framer rtl
`ifndef SPI_REGISTER_TRANSACTION_FRAMER_ASSERT_SVH
`define SPI_REGISTER_TRANSACTION_FRAMER_ASSERT_SVH

// same-cycle implication on clk, off during reset
`define SRTF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, off during reset
`define SRTF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/srtf_pkg.sv]
`timescale 1ns / 1ps

package srtf_pkg;

    // byte counters follow the 4-bit byte_count field
    localparam int unsigned CNT_W = 4;

    // request kinds on the input channel
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_RETURN = 1'b1;

    localparam logic [7:0]  FLAG_WRITE  = 8'h80;
    localparam logic [7:0]  FLAG_SUB    = 8'h40;
    localparam logic [7:0]  EXT_MARK    = 8'h80;
    localparam logic [14:0] SHORT_LIMIT = 15'd128;

    typedef enum logic [1:0] {
        TX_IDLE,
        TX_HDR,
        TX_DATA
    } tx_state_t;

    typedef struct packed {
        logic       vld;
        logic       last;
        logic [7:0] data;
    } tx_beat_t;

    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  len;
    } hdr_t;

    typedef struct packed {
        logic start;
        logic cancel;
        logic byte_vld;
        logic take;
    } rx_ctl_t;

    // header bytes, byte 0 in the low lane
    function automatic hdr_t build_header(
        input logic        is_write,
        input logic [5:0]  reg_file,
        input logic        use_sub,
        input logic [14:0] sub_offset
    );
        hdr_t       h;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        b0 = {2'b00, reg_file};
        b1 = 8'h00;
        b2 = 8'h00;
        h.len = 2'd1;
        if (is_write)
        begin
            b0 = b0 | FLAG_WRITE;
        end
        if (use_sub)
        begin
            b0 = b0 | FLAG_SUB;
            if (sub_offset < SHORT_LIMIT)
            begin
                b1 = sub_offset[7:0];
                h.len = 2'd2;
            end
            else
            begin
                b1 = EXT_MARK | {1'b0, sub_offset[6:0]};
                b2 = sub_offset[14:7];
                h.len = 2'd3;
            end
        end
        h.bytes = {b2, b1, b0};
        return h;
    endfunction

endpackage

[rtl/srtf_tx.sv]
`timescale 1ns / 1ps

module srtf_tx #(
    parameter int unsigned DATA_BYTES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  srtf_pkg::hdr_t                hdr,
    input  logic [DATA_BYTES*8-1:0]       data,
    input  logic [srtf_pkg::CNT_W-1:0]    count,
    input  logic                          adv,
    output srtf_pkg::tx_beat_t            beat,
    output logic                          busy
);

    localparam int unsigned DATA_W = DATA_BYTES * 8;
    localparam int unsigned CW     = srtf_pkg::CNT_W;

    srtf_pkg::tx_state_t state_reg, state_next;
    logic [23:0]         hdr_sr_reg, hdr_sr_next;
    logic [1:0]          hdr_left_reg, hdr_left_next;
    logic [DATA_W-1:0]   data_sr_reg, data_sr_next;
    logic [CW-1:0]       data_left_reg, data_left_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srtf_pkg::TX_IDLE;
            hdr_left_reg  <= '0;
            data_left_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hdr_left_reg  <= hdr_left_next;
            data_left_reg <= data_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_sr_reg  <= hdr_sr_next;
        data_sr_reg <= data_sr_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        hdr_sr_next    = hdr_sr_reg;
        hdr_left_next  = hdr_left_reg;
        data_sr_next   = data_sr_reg;
        data_left_next = data_left_reg;
        beat           = '0;
        case (state_reg)
            srtf_pkg::TX_IDLE:
            begin
                if (load)
                begin
                    state_next     = srtf_pkg::TX_HDR;
                    hdr_sr_next    = hdr.bytes;
                    hdr_left_next  = hdr.len;
                    data_sr_next   = data;
                    data_left_next = count;
                end
            end
            srtf_pkg::TX_HDR:
            begin
                beat.vld  = 1'b1;
                beat.data = hdr_sr_reg[7:0];
                if (adv)
                begin
                    hdr_sr_next   = hdr_sr_reg >> 8;
                    hdr_left_next = hdr_left_reg - 2'd1;
                    if (hdr_left_reg == 2'd1)
                    begin
                        state_next = srtf_pkg::TX_DATA;
                    end
                end
            end
            srtf_pkg::TX_DATA:
            begin
                beat.vld  = 1'b1;
                beat.data = data_sr_reg[7:0];
                beat.last = (data_left_reg == CW'(1));
                if (adv)
                begin
                    data_sr_next   = data_sr_reg >> 8;
                    data_left_next = data_left_reg - CW'(1);
                    if (data_left_reg == CW'(1))
                    begin
                        state_next = srtf_pkg::TX_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = srtf_pkg::TX_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != srtf_pkg::TX_IDLE);

endmodule

[rtl/srtf_rx.sv]
`timescale 1ns / 1ps

module srtf_rx #(
    parameter int unsigned DATA_BYTES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  srtf_pkg::rx_ctl_t             ctl,
    input  logic [srtf_pkg::CNT_W-1:0]    count,
    input  logic [7:0]                    byte_in,
    output logic                          done,
    output logic [DATA_BYTES*8-1:0]       value
);

    localparam int unsigned CW = srtf_pkg::CNT_W;

    logic          pending_reg, pending_next;
    logic [CW-1:0] expected_reg, expected_next;
    logic [CW-1:0] received_reg, received_next;
    logic          done_reg, done_next;
    logic [7:0]    acc_reg [DATA_BYTES];
    logic          hit;

    assign hit = ctl.byte_vld && pending_reg && (received_reg < expected_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= 1'b0;
            expected_reg <= '0;
            received_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            pending_reg  <= pending_next;
            expected_reg <= expected_next;
            received_reg <= received_next;
            done_reg     <= done_next;
        end
    end

    always_comb
    begin
        pending_next  = pending_reg;
        expected_next = expected_reg;
        received_next = received_reg;
        done_next     = done_reg;
        if (ctl.start)
        begin
            pending_next  = 1'b1;
            expected_next = count;
            received_next = '0;
        end
        else if (ctl.cancel)
        begin
            pending_next = 1'b0;
        end
        else if (hit)
        begin
            received_next = received_reg + CW'(1);
            if (received_next == expected_reg)
            begin
                pending_next = 1'b0;
                done_next    = 1'b1;
            end
        end
        if (ctl.take)
        begin
            done_next = 1'b0;
        end
    end

    // one byte lane written per returned byte
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DATA_BYTES; i++)
        begin
            if (ctl.start)
            begin
                acc_reg[i] <= 8'h00;
            end
            else if (hit && (received_reg == CW'(i)))
            begin
                acc_reg[i] <= byte_in;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < DATA_BYTES; i++)
        begin
            value[i*8 +: 8] = acc_reg[i];
        end
    end

    assign done = done_reg;

endmodule

[rtl/spi_register_transaction_framer.sv]
`timescale 1ns / 1ps
`include "spi_register_transaction_framer_assert.svh"
// spi register access framer, host side
// input channel (in_valid / in_stall) carries two kinds of request:
//   cmd = 0: register access, header plus data bytes are framed out
//   cmd = 1: one byte returned by the slave during a read data phase
// output channel (out_valid / out_stall) carries one result per beat:
//   either an outgoing bus byte (byte_valid, frame_last on the final one)
//   or a finished read value (read_valid with read_value)
// a register access emits 1 to 3 header bytes then 1 to MAX_DATA_BYTES
// data bytes, one byte per cycle from a byte shift register while the
// output is not stalled; the first byte enters the output register once
// the sequencer has left idle; in_stall is high while the bytes go out;
// a returned byte that does not complete the read leaves in_stall low, and a
// completed read holds in_stall until its result enters the output register
// requests with a length of zero or beyond MAX_DATA_BYTES are dropped
// a stalled output keeps its beat and the byte shift register waits
// reset clears the sequencer, the pending read and the output valid flag
module spi_register_transaction_framer #(
    parameter int unsigned MAX_DATA_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic        is_write,
    input  logic [5:0]  reg_file,
    input  logic        use_sub,
    input  logic [14:0] sub_offset,
    input  logic [3:0]  byte_count,
    input  logic [63:0] write_value,
    input  logic [7:0]  miso_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  mosi_byte,
    output logic        byte_valid,
    output logic        frame_last,
    output logic        read_valid,
    output logic [63:0] read_value
);

    localparam int unsigned DATA_W = MAX_DATA_BYTES * 8;
    localparam int unsigned CW     = srtf_pkg::CNT_W;

    // input side
    logic               in_acc;
    logic               len_ok;
    logic               req;
    srtf_pkg::hdr_t     hdr;
    logic [DATA_W-1:0]  tx_data;

    // serializer and read assembler
    srtf_pkg::tx_beat_t beat;
    logic               tx_busy;
    srtf_pkg::rx_ctl_t  rx_ctl;
    logic               rx_done;
    logic [DATA_W-1:0]  rx_value;

    // output register
    logic               out_free;
    logic               rx_take;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         mosi_reg, mosi_next;
    logic               bv_reg, bv_next;
    logic               last_reg, last_next;
    logic               rv_reg, rv_next;
    logic [63:0]        rval_reg, rval_next;

    // busy while bytes go out or a read result waits to enter the output
    assign in_stall = tx_busy || rx_done;
    assign in_acc   = in_valid && !in_stall;
    assign len_ok   = (byte_count != '0) && (byte_count <= CW'(MAX_DATA_BYTES));
    assign req      = in_acc && (cmd == srtf_pkg::CMD_ACCESS) && len_ok;

    assign hdr     = srtf_pkg::build_header(is_write, reg_file, use_sub, sub_offset);
    // reads clock out zero filler bytes
    assign tx_data = is_write ? write_value[DATA_W-1:0] : '0;

    assign out_free = !out_valid_reg || !out_stall;
    assign rx_take  = out_free && rx_done && !beat.vld;

    assign rx_ctl.start    = req && !is_write;
    assign rx_ctl.cancel   = req && is_write;
    assign rx_ctl.byte_vld = in_acc && (cmd == srtf_pkg::CMD_RETURN);
    assign rx_ctl.take     = rx_take;

    srtf_tx #(
        .DATA_BYTES (MAX_DATA_BYTES)
    ) u_tx (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (req),
        .hdr   (hdr),
        .data  (tx_data),
        .count (byte_count),
        .adv   (out_free),
        .beat  (beat),
        .busy  (tx_busy)
    );

    srtf_rx #(
        .DATA_BYTES (MAX_DATA_BYTES)
    ) u_rx (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (rx_ctl),
        .count   (byte_count),
        .byte_in (miso_byte),
        .done    (rx_done),
        .value   (rx_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mosi_reg <= mosi_next;
        bv_reg   <= bv_next;
        last_reg <= last_next;
        rv_reg   <= rv_next;
        rval_reg <= rval_next;
    end

    // output register load: a bus byte first, else a finished read
    always_comb
    begin
        out_valid_next = out_valid_reg;
        mosi_next      = mosi_reg;
        bv_next        = bv_reg;
        last_next      = last_reg;
        rv_next        = rv_reg;
        rval_next      = rval_reg;
        if (out_free)
        begin
            out_valid_next = beat.vld || rx_take;
            if (beat.vld)
            begin
                mosi_next = beat.data;
                bv_next   = 1'b1;
                last_next = beat.last;
                rv_next   = 1'b0;
                rval_next = '0;
            end
            else
            begin
                mosi_next = 8'h00;
                bv_next   = 1'b0;
                last_next = 1'b0;
                rv_next   = 1'b1;
                rval_next = 64'(rx_value);
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign mosi_byte  = mosi_reg;
    assign byte_valid = bv_reg;
    assign frame_last = last_reg;
    assign read_valid = rv_reg;
    assign read_value = rval_reg;

    `SRTF_ASSERT_IMP(a_one_kind, out_valid_reg, $onehot({bv_reg, rv_reg}), "beat kind mixed")
    `SRTF_ASSERT_IMP(a_last_is_byte, out_valid_reg && last_reg, bv_reg, "frame_last without a byte")
    `SRTF_ASSERT_IMP(a_no_overlap, tx_busy, !rx_done, "read result pending during a frame")
    `SRTF_ASSERT_NXT(a_req_starts, req, tx_busy, "request did not start the serializer")

endmodule

[bench/spi_register_transaction_framer_tb.sv]
`timescale 1ns / 1ps

module spi_register_transaction_framer_tb;

    localparam int unsigned DATA_BYTES_MAX = 8;
    localparam int unsigned RANDOM_ITEMS   = 126;

    // access direction
    localparam logic DIR_READ  = 1'b0;
    localparam logic DIR_WRITE = 1'b1;

    // header flag for a read and the filler sent while reading
    localparam logic [7:0] FLAG_READ = 8'h00;
    localparam logic [7:0] FILLER    = 8'h00;

    // one input request, plus a flag telling the driver to drain first
    typedef struct {
        logic        cmd;
        logic        is_write;
        logic [5:0]  reg_file;
        logic        use_sub;
        logic [14:0] sub_offset;
        logic [3:0]  byte_count;
        logic [63:0] write_value;
        logic [7:0]  miso_byte;
        logic        drain_first;
    } bus_req_t;

    // one output beat: either a bus byte or a finished read value
    typedef struct {
        logic [7:0]  mosi;
        logic        byte_valid;
        logic        frame_last;
        logic        read_valid;
        logic [63:0] read_value;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        cmd = 1'b0;
    logic        is_write = 1'b0;
    logic [5:0]  reg_file = '0;
    logic        use_sub = 1'b0;
    logic [14:0] sub_offset = '0;
    logic [3:0]  byte_count = '0;
    logic [63:0] write_value = '0;
    logic [7:0]  miso_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  mosi_byte;
    logic        byte_valid;
    logic        frame_last;
    logic        read_valid;
    logic [63:0] read_value;

    // requests waiting to be driven, and beats the framer still owes us
    bus_req_t pending_reqs[$];
    beat_t    expected_beats[$];
    bus_req_t cur_req;
    bus_req_t nxt;
    logic     drain_next = 1'b0;

    // shadow of the framer's read collection state
    logic        rd_pending = 1'b0;
    logic [3:0]  rd_want = '0;
    logic [3:0]  rd_got = '0;
    logic [63:0] rd_value = '0;

    // bookkeeping
    int err_count = 0;
    int n_writes = 0;
    int n_reads = 0;
    int n_reads_done = 0;
    int n_rejected = 0;
    int n_stray = 0;
    int n_beats = 0;

    // driver and monitor working variables
    int   send_gap = 0;
    int   stall_left = 0;
    logic holding;
    logic launch;

    spi_register_transaction_framer #(
        .MAX_DATA_BYTES(DATA_BYTES_MAX)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .is_write(is_write),
        .reg_file(reg_file),
        .use_sub(use_sub),
        .sub_offset(sub_offset),
        .byte_count(byte_count),
        .write_value(write_value),
        .miso_byte(miso_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .mosi_byte(mosi_byte),
        .byte_valid(byte_valid),
        .frame_last(frame_last),
        .read_valid(read_valid),
        .read_value(read_value)
    );

    // 10 ns clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // offsets split between short form, extended form and anything
    function automatic logic [14:0] rand_offset();
        case ($urandom_range(0, 2))
            0: return 15'($urandom_range(0, 127));
            1: return 15'($urandom_range(128, 32767));
            default: return 15'($urandom);
        endcase
    endfunction

    function automatic logic [3:0] rand_count();
        return 4'($urandom_range(1, DATA_BYTES_MAX));
    endfunction

    // length outside 1..max, dropped by the framer
    function automatic logic [3:0] bad_count();
        if ($urandom_range(0, 1) == 0)
            return 4'd0;
        return 4'($urandom_range(DATA_BYTES_MAX + 1, 15));
    endfunction

    // register access request, miso lane carries junk
    function automatic bus_req_t mk_access(
        input logic        wr,
        input logic [5:0]  rf,
        input logic        us,
        input logic [14:0] off,
        input logic [3:0]  cnt,
        input logic [63:0] val
    );
        bus_req_t r;
        r.cmd = srtf_pkg::CMD_ACCESS;
        r.is_write = wr;
        r.reg_file = rf;
        r.use_sub = us;
        r.sub_offset = off;
        r.byte_count = cnt;
        r.write_value = val;
        r.miso_byte = 8'($urandom);
        r.drain_first = 1'b0;
        return r;
    endfunction

    // returned slave byte, access fields carry junk
    function automatic bus_req_t mk_return(input logic [7:0] b);
        bus_req_t r;
        r.cmd = srtf_pkg::CMD_RETURN;
        r.is_write = 1'($urandom);
        r.reg_file = 6'($urandom);
        r.use_sub = 1'($urandom);
        r.sub_offset = 15'($urandom);
        r.byte_count = 4'($urandom);
        r.write_value = rand64();
        r.miso_byte = b;
        r.drain_first = 1'b0;
        return r;
    endfunction

    task automatic queue_req(input bus_req_t r);
        r.drain_first = drain_next;
        drain_next = 1'b0;
        pending_reqs.push_back(r);
    endtask

    // idle length: mostly none, some short, a few long; none in quiet windows
    function automatic int pick_gap(input logic quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // framer prediction: beats owed for one accepted request
    // ------------------------------------------------------------------

    task automatic frame_request(input bus_req_t r);
        logic [7:0] hdr [3];
        int         hlen;
        int         total;
        beat_t      bt;
        // returned byte: only counts while a read is collecting
        if (r.cmd == srtf_pkg::CMD_RETURN)
        begin
            if (!rd_pending || rd_got >= rd_want || rd_got >= DATA_BYTES_MAX)
            begin
                n_stray++;
                return;
            end
            rd_value = rd_value | ({56'd0, r.miso_byte} << (8 * rd_got));
            rd_got = rd_got + 4'd1;
            // partial read gives nothing yet
            if (rd_got < rd_want)
                return;
            rd_pending = 1'b0;
            n_reads_done++;
            bt.mosi = 8'd0;
            bt.byte_valid = 1'b0;
            bt.frame_last = 1'b0;
            bt.read_valid = 1'b1;
            bt.read_value = rd_value;
            expected_beats.push_back(bt);
            return;
        end
        // out-of-range length is dropped with no state change
        if (r.byte_count == 4'd0 || r.byte_count > DATA_BYTES_MAX)
        begin
            n_rejected++;
            return;
        end
        // header: flags and file id, then an optional short or extended offset
        hdr[0] = {2'b00, r.reg_file} | (r.is_write ? srtf_pkg::FLAG_WRITE : FLAG_READ);
        hdr[1] = 8'd0;
        hdr[2] = 8'd0;
        hlen = 1;
        if (r.use_sub)
        begin
            hdr[0] = hdr[0] | srtf_pkg::FLAG_SUB;
            if (r.sub_offset < srtf_pkg::SHORT_LIMIT)
            begin
                hdr[1] = r.sub_offset[7:0];
                hlen = 2;
            end
            else
            begin
                hdr[1] = srtf_pkg::EXT_MARK | {1'b0, r.sub_offset[6:0]};
                hdr[2] = r.sub_offset[14:7];
                hlen = 3;
            end
        end
        total = hlen + int'(r.byte_count);
        for (int k = 0; k < total; k++)
        begin
            // data lsb first on writes, filler on reads
            if (k < hlen)
                bt.mosi = hdr[k];
            else if (r.is_write)
                bt.mosi = r.write_value[8 * (k - hlen) +: 8];
            else
                bt.mosi = FILLER;
            bt.byte_valid = 1'b1;
            bt.frame_last = (k == total - 1);
            bt.read_valid = 1'b0;
            bt.read_value = 64'd0;
            expected_beats.push_back(bt);
        end
        // any accepted access drops a read still collecting
        if (r.is_write)
        begin
            rd_pending = 1'b0;
            n_writes++;
        end
        else
        begin
            rd_pending = 1'b1;
            rd_want = r.byte_count;
            rd_got = 4'd0;
            rd_value = 64'd0;
            n_reads++;
        end
    endtask

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("%0t mismatch: %s", $time, msg);
    endfunction

    // ------------------------------------------------------------------
    // driver: presents queued requests, predicts each one on acceptance
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            holding = in_valid;
            if (in_valid && !in_stall)
            begin
                frame_request(cur_req);
                holding = 1'b0;
            end
            // payload stays put while the framer stalls us
            if (!holding)
            begin
                launch = 1'b0;
                if (send_gap > 0)
                    send_gap--;
                else if (pending_reqs.size() != 0
                         && !(pending_reqs[0].drain_first && expected_beats.size() != 0))
                begin
                    cur_req = pending_reqs.pop_front();
                    launch = 1'b1;
                    // quiet windows: 1 and 2 of every four
                    send_gap = pick_gap((($time / 4000) % 4) inside {1, 2});
                end
                in_valid <= launch;
                if (launch)
                begin
                    cmd <= cur_req.cmd;
                    is_write <= cur_req.is_write;
                    reg_file <= cur_req.reg_file;
                    use_sub <= cur_req.use_sub;
                    sub_offset <= cur_req.sub_offset;
                    byte_count <= cur_req.byte_count;
                    write_value <= cur_req.write_value;
                    miso_byte <= cur_req.miso_byte;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random back-pressure, checks each beat against the oldest
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_beats++;
                if (expected_beats.size() == 0)
                begin
                    note_error($sformatf(
                        "unexpected beat mosi=%h bv=%b last=%b rv=%b val=%h",
                        mosi_byte, byte_valid, frame_last, read_valid, read_value));
                end
                else
                begin
                    beat_t ex;
                    ex = expected_beats.pop_front();
                    if (mosi_byte !== ex.mosi || byte_valid !== ex.byte_valid
                        || frame_last !== ex.frame_last || read_valid !== ex.read_valid
                        || read_value !== ex.read_value)
                    begin
                        note_error($sformatf(
                            "exp mosi=%h bv=%b last=%b rv=%b val=%h / got %h %b %b %b %h",
                            ex.mosi, ex.byte_valid, ex.frame_last, ex.read_valid,
                            ex.read_value, mosi_byte, byte_valid, frame_last,
                            read_valid, read_value));
                    end
                end
            end
            // quiet windows: 2 and 3 of every four
            if (stall_left == 0)
                stall_left = pick_gap((($time / 4000) % 4) inside {2, 3});
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------

    initial
    begin
        int counted;
        int pick;
        int n;

        // directed: stray byte straight after reset
        queue_req(mk_return(8'h5A));
        // header flag combinations, offset boundaries, data extremes
        queue_req(mk_access(DIR_WRITE, 6'd0, 1'b0, 15'd0, 4'd1, 64'd0));
        // offset ignored without sub-index
        queue_req(mk_access(DIR_WRITE, 6'd63, 1'b0, 15'h7FFF, 4'd8, '1));
        queue_req(mk_access(DIR_WRITE, 6'h2A, 1'b1, 15'd0, 4'd2, rand64()));
        queue_req(mk_access(DIR_WRITE, 6'h15, 1'b1, 15'd127, 4'd3, rand64()));
        queue_req(mk_access(DIR_WRITE, 6'h01, 1'b1, 15'd128, 4'd8, rand64()));
        // longest frame: extended offset plus eight data bytes
        queue_req(mk_access(DIR_WRITE, 6'd63, 1'b1, 15'h7FFF, 4'd8, rand64()));
        // single byte read, no sub-index
        queue_req(mk_access(DIR_READ, 6'h05, 1'b0, 15'h1234, 4'd1, rand64()));
        queue_req(mk_return(8'hFF));
        // three byte read, extended offset
        queue_req(mk_access(DIR_READ, 6'h15, 1'b1, 15'd200, 4'd3, rand64()));
        queue_req(mk_return(8'h00));
        queue_req(mk_return(8'hA5));
        queue_req(mk_return(8'hFF));
        // read abandoned by a write, then a byte with nothing collecting
        queue_req(mk_access(DIR_READ, 6'h3C, 1'b1, 15'd64, 4'd4, rand64()));
        queue_req(mk_return(8'h3C));
        queue_req(mk_access(DIR_WRITE, 6'h11, 1'b1, 15'd300, 4'd1, rand64()));
        queue_req(mk_return(8'h77));
        // read restarted by another read
        queue_req(mk_access(DIR_READ, 6'h22, 1'b0, 15'd0, 4'd2, rand64()));
        queue_req(mk_return(8'h81));
        queue_req(mk_access(DIR_READ, 6'h2E, 1'b1, 15'd127, 4'd1, rand64()));
        queue_req(mk_return(8'h42));
        // sender holds off until the framer has drained
        drain_next = 1'b1;
        // lengths out of range
        queue_req(mk_access(DIR_READ, 6'h0F, 1'b1, 15'd5, 4'd0, rand64()));
        queue_req(mk_access(DIR_WRITE, 6'h30, 1'b0, 15'd0, 4'd9, rand64()));
        queue_req(mk_access(DIR_WRITE, 6'h3F, 1'b1, 15'h4000, 4'd15, '1));

        // random: mostly complete writes and reads with their returned bytes
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            drain_next = ($urandom_range(0, 24) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 38)
            begin
                queue_req(mk_access(DIR_WRITE, 6'($urandom), 1'($urandom), rand_offset(),
                                    rand_count(), rand64()));
                counted++;
            end
            else if (pick < 82)
            begin
                nxt = mk_access(DIR_READ, 6'($urandom), 1'($urandom), rand_offset(),
                                rand_count(), rand64());
                queue_req(nxt);
                counted++;
                n = nxt.byte_count;
                // now and then the read is left open and later abandoned
                if (pick >= 78)
                    n = $urandom_range(0, n - 1);
                repeat (n)
                begin
                    queue_req(mk_return(8'($urandom)));
                    counted++;
                end
            end
            else if (pick < 90)
            begin
                // stray, unless a read was left open just before
                queue_req(mk_return(8'($urandom)));
            end
            else
            begin
                queue_req(mk_access(1'($urandom), 6'($urandom), 1'($urandom), rand_offset(),
                                    bad_count(), rand64()));
            end
        end

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // everything sent, everything owed has arrived, then a short settle
        while (pending_reqs.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d writes, %0d reads (%0d completed), %0d dropped lengths",
                 n_writes, n_reads, n_reads_done, n_rejected);
        $display("%0d ignored returned bytes, %0d output beats checked", n_stray, n_beats);
        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("%0d mismatches in total", err_count);
            $display("DONE: errors detected");
        end
        $finish;
    end

    // hang guard
    initial
    begin
        #5ms;
        $display("timeout with %0d requests and %0d beats outstanding",
                 pending_reqs.size(), expected_beats.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[spi_register_transaction_framer.f]
+incdir+rtl
rtl/srtf_pkg.sv
rtl/srtf_tx.sv
rtl/srtf_rx.sv
rtl/spi_register_transaction_framer.sv
bench/spi_register_transaction_framer_tb.sv
